>>> rtl/fapq_pkg.sv
// Package: request and response types, codes and control struct for the priority FIFO queue.
package fapq_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int ID_BITS            = 32;
    localparam int ITEM_BITS          = 32;

    // request codes
    localparam logic [1:0] REQ_INSERT     = 2'd0;
    localparam logic [1:0] REQ_POP_OLDEST = 2'd1;
    localparam logic [1:0] REQ_POP_MAX    = 2'd2;
    localparam logic [1:0] REQ_RESERVED   = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [ITEM_BITS-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0] entry_id;
        logic [1:0]         status;
    } rsp_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

>>> rtl/fifo_and_max_priority_queue_core.sv
// Top level: priority FIFO queue built from a chain of slot cells plus a small controller.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------
//  req     | in  | req_valid / req_ready | fapq_pkg::req_t  (req_type, item_value)
//  rsp     | out | rsp_valid / rsp_ready | fapq_pkg::rsp_t  (entry_id, status)
//
// Insert, pop-oldest and any request that fails (empty or full) complete in the
// accept cycle; the response is registered and shows the next cycle.
// Pop-max lets the compare wave cross the whole cell chain; then the winner is
// removed and the chain compacts.
// Reset empties the queue at once (slot valid bits clear) and sets next id to 1.
// A response held by rsp_ready low blocks new requests only until it is taken.
module fifo_and_max_priority_queue_core #(
    parameter int DEPTH      = fapq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = fapq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fapq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fapq_pkg::rsp_t rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // cell chain wiring
    fapq_pkg::cell_ctrl_t         ctrl;
    logic [IDX_W-1:0]             remove_pos;
    logic [VALUE_BITS-1:0]        ins_value;
    logic [DEPTH-1:0]             valid_vec;
    logic [VALUE_BITS-1:0]        value_w    [DEPTH];
    logic [fapq_pkg::ID_BITS-1:0] id_w       [DEPTH];
    logic [DEPTH-1:0]             wave_found_vec;
    logic [VALUE_BITS-1:0]        wave_val_w [DEPTH];
    logic [IDX_W-1:0]             wave_idx_w [DEPTH];
    logic [fapq_pkg::ID_BITS-1:0] wave_id_w  [DEPTH];

    // controller state
    fapq_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]             scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]             occ_reg, occ_next;
    logic [fapq_pkg::ID_BITS-1:0] next_id_reg, next_id_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    fapq_pkg::rsp_t               rsp_reg, rsp_next;
    logic                         accept;

    // values wider than the stored width are truncated, narrower zero-extended
    assign ins_value = VALUE_BITS'(req.item_value);

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic                         prev_valid;
            logic                         up_valid;
            logic [VALUE_BITS-1:0]        up_value;
            logic [fapq_pkg::ID_BITS-1:0] up_id;
            logic                         w_found;
            logic [VALUE_BITS-1:0]        w_val;
            logic [IDX_W-1:0]             w_idx;
            logic [fapq_pkg::ID_BITS-1:0] w_id;

            if (k == 0)
            begin : g_first
                assign prev_valid = 1'b1;
                assign w_found    = 1'b0;
                assign w_val      = '0;
                assign w_idx      = '0;
                assign w_id       = '0;
            end
            else
            begin : g_mid
                assign prev_valid = valid_vec[k-1];
                assign w_found    = wave_found_vec[k-1];
                assign w_val      = wave_val_w[k-1];
                assign w_idx      = wave_idx_w[k-1];
                assign w_id       = wave_id_w[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign up_valid = 1'b0;
                assign up_value = '0;
                assign up_id    = '0;
            end
            else
            begin : g_below
                assign up_valid = valid_vec[k+1];
                assign up_value = value_w[k+1];
                assign up_id    = id_w[k+1];
            end

            fapq_cell #(
                .DEPTH      (DEPTH),
                .VALUE_BITS (VALUE_BITS),
                .INDEX      (k)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .remove_pos    (remove_pos),
                .ins_value     (ins_value),
                .ins_id        (next_id_reg),
                .prev_valid    (prev_valid),
                .up_valid      (up_valid),
                .up_value      (up_value),
                .up_id         (up_id),
                .wave_in_found (w_found),
                .wave_in_val   (w_val),
                .wave_in_idx   (w_idx),
                .wave_in_id    (w_id),
                .valid         (valid_vec[k]),
                .value         (value_w[k]),
                .id            (id_w[k]),
                .wave_found    (wave_found_vec[k]),
                .wave_val      (wave_val_w[k]),
                .wave_idx      (wave_idx_w[k]),
                .wave_id       (wave_id_w[k])
            );
        end
    endgenerate

    // new request only when idle and the response slot is free or draining
    assign req_ready = (state_reg == fapq_pkg::S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fapq_pkg::S_IDLE;
            scan_cnt_reg  <= '0;
            occ_reg       <= '0;
            next_id_reg   <= fapq_pkg::ID_BITS'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            occ_reg       <= occ_next;
            next_id_reg   <= next_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        occ_next       = occ_reg;
        next_id_next   = next_id_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctrl           = '0;
        remove_pos     = '0;

        unique case (state_reg)
            fapq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type) inside
                        fapq_pkg::REQ_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (occ_reg == FULL_CNT)
                            begin
                                rsp_next = '{entry_id: '0, status: fapq_pkg::STATUS_FULL};
                            end
                            else
                            begin
                                ctrl.insert  = 1'b1;
                                occ_next     = occ_reg + CNT_W'(1);
                                next_id_next = next_id_reg + fapq_pkg::ID_BITS'(1);
                                rsp_next     = '{entry_id: next_id_reg,
                                                 status:   fapq_pkg::STATUS_OK};
                            end
                        end
                        fapq_pkg::REQ_POP_OLDEST:
                        begin
                            rsp_valid_next = 1'b1;
                            if (occ_reg == '0)
                            begin
                                rsp_next = '{entry_id: '0, status: fapq_pkg::STATUS_EMPTY};
                            end
                            else
                            begin
                                ctrl.remove = 1'b1;
                                occ_next    = occ_reg - CNT_W'(1);
                                rsp_next    = '{entry_id: id_w[0],
                                                status:   fapq_pkg::STATUS_OK};
                            end
                        end
                        fapq_pkg::REQ_POP_MAX, fapq_pkg::REQ_RESERVED:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = '{entry_id: '0, status: fapq_pkg::STATUS_EMPTY};
                            end
                            else
                            begin
                                // let the wave flush through the whole chain
                                state_next    = fapq_pkg::S_SCAN;
                                scan_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = rsp_valid_reg && !rsp_ready;
                        end
                    endcase
                end
            end
            fapq_pkg::S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == FULL_CNT)
                begin
                    // last cell now holds the max over a settled chain
                    ctrl.remove    = 1'b1;
                    remove_pos     = wave_idx_w[DEPTH-1];
                    occ_next       = occ_reg - CNT_W'(1);
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{entry_id: wave_id_w[DEPTH-1],
                                       status:   fapq_pkg::STATUS_OK};
                    state_next     = fapq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fapq_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // occupancy counter and the slot valid bits must agree
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy does not match slot valid bits");

    // valid slots stay compacted toward slot 0
    a_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + DEPTH'(1))) == '0)
        else $error("slot valid bits not compacted");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy above capacity");

    // a scan only runs on a non-empty queue, so the wave must have a winner
    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fapq_pkg::S_SCAN && scan_cnt_reg == FULL_CNT)
            |-> wave_found_vec[DEPTH-1])
        else $error("max search finished without a candidate");

    // a response that was not taken must still be pending next cycle
    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("pending response lost or changed");
`endif

endmodule

>>> rtl/fapq_cell.sv
// One queue slot: entry storage, compaction shift and one stage of the max-search wave.
module fapq_cell #(
    parameter int DEPTH      = fapq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = fapq_pkg::VALUE_BITS_DEFAULT,
    parameter int INDEX      = 0,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fapq_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]            remove_pos,
    input  logic [VALUE_BITS-1:0]       ins_value,
    input  logic [fapq_pkg::ID_BITS-1:0] ins_id,
    input  logic                        prev_valid,
    input  logic                        up_valid,
    input  logic [VALUE_BITS-1:0]       up_value,
    input  logic [fapq_pkg::ID_BITS-1:0] up_id,
    input  logic                        wave_in_found,
    input  logic [VALUE_BITS-1:0]       wave_in_val,
    input  logic [IDX_W-1:0]            wave_in_idx,
    input  logic [fapq_pkg::ID_BITS-1:0] wave_in_id,
    output logic                        valid,
    output logic [VALUE_BITS-1:0]       value,
    output logic [fapq_pkg::ID_BITS-1:0] id,
    output logic                        wave_found,
    output logic [VALUE_BITS-1:0]       wave_val,
    output logic [IDX_W-1:0]            wave_idx,
    output logic [fapq_pkg::ID_BITS-1:0] wave_id
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                         valid_reg, valid_next;
    logic [VALUE_BITS-1:0]        value_reg, value_next;
    logic [fapq_pkg::ID_BITS-1:0] id_reg, id_next;
    logic                         wave_found_reg;
    logic [VALUE_BITS-1:0]        wave_val_reg, wave_val_next;
    logic [IDX_W-1:0]             wave_idx_reg, wave_idx_next;
    logic [fapq_pkg::ID_BITS-1:0] wave_id_reg, wave_id_next;
    logic                         take_self;

    // slot update: insert into first free slot, or shift down above removed slot
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        id_next    = id_reg;
        if (ctrl.insert && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            value_next = ins_value;
            id_next    = ins_id;
        end
        else if (ctrl.remove && (MY_IDX >= remove_pos))
        begin
            valid_next = up_valid;
            value_next = up_value;
            id_next    = up_id;
        end
    end

    // wave stage: ties keep the earlier candidate
    always_comb
    begin
        take_self     = valid_reg && (!wave_in_found || (value_reg > wave_in_val));
        wave_val_next = take_self ? value_reg : wave_in_val;
        wave_idx_next = take_self ? MY_IDX : wave_in_idx;
        wave_id_next  = take_self ? id_reg : wave_in_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            wave_found_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            wave_found_reg <= wave_in_found | valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        id_reg       <= id_next;
        wave_val_reg <= wave_val_next;
        wave_idx_reg <= wave_idx_next;
        wave_id_reg  <= wave_id_next;
    end

    assign valid      = valid_reg;
    assign value      = value_reg;
    assign id         = id_reg;
    assign wave_found = wave_found_reg;
    assign wave_val   = wave_val_reg;
    assign wave_idx   = wave_idx_reg;
    assign wave_id    = wave_id_reg;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the priority FIFO queue: random requests, response checking.
module testbench;

    localparam int DEPTH      = fapq_pkg::DEPTH_DEFAULT;
    localparam int VALUE_BITS = fapq_pkg::VALUE_BITS_DEFAULT;
    localparam logic [fapq_pkg::ITEM_BITS-1:0] VALUE_MASK =
        (VALUE_BITS >= fapq_pkg::ITEM_BITS) ? '1 :
        ((fapq_pkg::ITEM_BITS'(1) << VALUE_BITS) - 1);

    // Slowest legal run per request is a pop-max scan plus both sides idling
    // at their longest; about 1150 requests, taken about 5x over.
    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int CLK_HALF       = 4;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    fapq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    fapq_pkg::rsp_t rsp;

    fifo_and_max_priority_queue_core #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Queue shadow: entries kept compacted in arrival order, index 0 is
    // the oldest, exactly like the cell chain is supposed to look.
    // ------------------------------------------------------------------
    logic [fapq_pkg::ITEM_BITS-1:0] held_value [DEPTH];
    logic [fapq_pkg::ID_BITS-1:0]   held_tag   [DEPTH];
    int                             held_count  = 0;
    logic [fapq_pkg::ID_BITS-1:0]   tag_counter = 1;   // wraps mod 2^32 like the hardware

    fapq_pkg::req_t pending_reqs [$];   // stimulus not yet presented
    fapq_pkg::rsp_t awaited_rsps [$];   // predicted responses, oldest first

    int error_count  = 0;
    int checked_rsps = 0;
    int n_inserted   = 0;
    int n_oldest     = 0;
    int n_max        = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int peak_count   = 0;

    // Apply one accepted request to the shadow and return the response it
    // must produce.
    function automatic fapq_pkg::rsp_t apply_request(fapq_pkg::req_t r);
        fapq_pkg::rsp_t outcome;
        int             pick;
        outcome.entry_id = '0;
        outcome.status   = fapq_pkg::STATUS_OK;
        if (r.req_type == fapq_pkg::REQ_INSERT) begin
            if (held_count >= DEPTH) begin
                outcome.status = fapq_pkg::STATUS_FULL;   // nothing stored, tag not consumed
                n_full++;
            end else begin
                held_value[held_count] = r.item_value & VALUE_MASK;
                held_tag[held_count]   = tag_counter;
                held_count++;
                outcome.entry_id = tag_counter;
                tag_counter++;
                n_inserted++;
                if (held_count > peak_count)
                    peak_count = held_count;
            end
        end else if (held_count == 0) begin
            outcome.status = fapq_pkg::STATUS_EMPTY;
            n_empty++;
        end else begin
            // Pop-oldest takes the head. Pop-max and the spare code 3
            // (decoded like pop-max) take the largest value; strict
            // compare keeps the oldest on a tie.
            pick = 0;
            if (r.req_type == fapq_pkg::REQ_POP_OLDEST) begin
                n_oldest++;
            end else begin
                n_max++;
                for (int k = 1; k < held_count; k++)
                    if (held_value[k] > held_value[pick])
                        pick = k;
            end
            outcome.entry_id = held_tag[pick];
            for (int k = pick; k + 1 < held_count; k++) begin
                held_value[k] = held_value[k + 1];
                held_tag[k]   = held_tag[k + 1];
            end
            held_count--;
        end
        return outcome;
    endfunction

    // Per-request random wait, with occasional stretches of no
    // idling at all so back-to-back traffic is also exercised.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    // Values: small range to force ties, the corner patterns, full random.
    function automatic logic [fapq_pkg::ITEM_BITS-1:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return fapq_pkg::ITEM_BITS'($urandom_range(0, 7));
            4: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(fapq_pkg::ITEM_BITS-1){1'b0}}};
                    default: return {1'b0, {(fapq_pkg::ITEM_BITS-1){1'b1}}};
                endcase
            end
            default: return fapq_pkg::ITEM_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] draw_pop();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 9)
            return fapq_pkg::REQ_POP_OLDEST;
        else if (roll < 18)
            return fapq_pkg::REQ_POP_MAX;
        return fapq_pkg::REQ_RESERVED;
    endfunction

    task automatic add_req(logic [1:0] code, logic [fapq_pkg::ITEM_BITS-1:0] value);
        fapq_pkg::req_t r;
        r.req_type   = code;
        r.item_value = value;
        pending_reqs.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: presents pending_reqs in order, holds valid and the
    // payload until accepted, and predicts the response at acceptance so
    // the prediction order matches the order the block sees.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int req_wait;
        int req_calm;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
            req_calm  = 0;
            req_wait  = draw_wait(req_calm);
        end else begin
            if (req_valid && req_ready) begin
                awaited_rsps.push_back(apply_request(req));
                req_wait = draw_wait(req_calm);
            end
            // channel is free when nothing is shown or the shown one just went
            if (!req_valid || req_ready) begin
                if (req_wait == 0 && pending_reqs.size() != 0) begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                end else begin
                    req_valid <= 1'b0;
                    if (req_wait != 0)
                        req_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: random back-pressure, each taken response checked
    // field by field against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int             rsp_wait;
        int             rsp_calm;
        fapq_pkg::rsp_t want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_calm  = 0;
            rsp_wait  = draw_wait(rsp_calm);
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (awaited_rsps.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected response, expected none, got id %0h status %0d",
                             $time, rsp.entry_id, rsp.status);
                end else begin
                    want = awaited_rsps.pop_front();
                    checked_rsps++;
                    if (rsp.entry_id !== want.entry_id) begin
                        error_count++;
                        $display("%0t: entry_id mismatch, expected %0h, got %0h",
                                 $time, want.entry_id, rsp.entry_id);
                    end
                    if (rsp.status !== want.status) begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                    end
                end
                rsp_wait = draw_wait(rsp_calm);
            end
            if (rsp_wait != 0) begin
                rsp_ready <= 1'b0;
                rsp_wait--;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int run_len;
        // Directed: pops on an empty queue (all three pop codes), value
        // extremes, a tie on the largest value, the spare code acting as
        // pop-max, a tie at zero, then drain back to empty.
        add_req(fapq_pkg::REQ_POP_OLDEST, '1);
        add_req(fapq_pkg::REQ_POP_MAX, '1);
        add_req(fapq_pkg::REQ_RESERVED, '0);
        add_req(fapq_pkg::REQ_INSERT, '0);
        add_req(fapq_pkg::REQ_INSERT, '1);
        add_req(fapq_pkg::REQ_INSERT, 32'd5);
        add_req(fapq_pkg::REQ_INSERT, '1);
        add_req(fapq_pkg::REQ_INSERT, 32'hAAAA_AAAA);
        add_req(fapq_pkg::REQ_INSERT, 32'h5555_5555);
        add_req(fapq_pkg::REQ_POP_MAX, '0);        // first of the two all-ones entries
        add_req(fapq_pkg::REQ_RESERVED, '1);       // second all-ones entry
        add_req(fapq_pkg::REQ_POP_OLDEST, '0);
        add_req(fapq_pkg::REQ_POP_MAX, '0);
        add_req(fapq_pkg::REQ_INSERT, 32'h5555_5555);
        add_req(fapq_pkg::REQ_POP_MAX, '0);        // older of the two equal values
        add_req(fapq_pkg::REQ_POP_OLDEST, '0);
        add_req(fapq_pkg::REQ_POP_OLDEST, '0);
        add_req(fapq_pkg::REQ_POP_OLDEST, '0);     // empty again
        add_req(fapq_pkg::REQ_INSERT, '0);
        add_req(fapq_pkg::REQ_INSERT, '0);
        add_req(fapq_pkg::REQ_POP_MAX, '0);
        add_req(fapq_pkg::REQ_POP_MAX, '0);
        add_req(fapq_pkg::REQ_POP_MAX, '0);

        // Random: cycle through mixed traffic, a fill burst long enough to
        // hit full and bounce off it, more mixed, and a drain burst long
        // enough to hit empty. Pop payloads are random too.
        phase = 0;
        while (pending_reqs.size() < 1125) begin
            case (phase % 4)
                1: begin
                    run_len = DEPTH + $urandom_range(1, 6);
                    repeat (run_len) add_req(fapq_pkg::REQ_INSERT, draw_value());
                end
                3: begin
                    run_len = DEPTH + $urandom_range(1, 6);
                    repeat (run_len) add_req(draw_pop(), draw_value());
                end
                default: begin
                    run_len = $urandom_range(10, 60);
                    repeat (run_len) begin
                        if ($urandom_range(0, 1) == 0)
                            add_req(fapq_pkg::REQ_INSERT, draw_value());
                        else
                            add_req(draw_pop(), draw_value());
                    end
                end
            endcase
            phase++;
        end

        wait (rst_n);
        wait (pending_reqs.size() == 0 && !req_valid);
        wait (awaited_rsps.size() == 0);
        // let any stray response show, with room for a whole pop-max scan
        repeat (2 * DEPTH + 16) @(posedge clk);

        $display("Checked %0d responses: %0d inserts, %0d pop-oldest, %0d pop-max,",
                 checked_rsps, n_inserted, n_oldest, n_max);
        $display("%0d inserts refused as full, %0d pops on empty, peak occupancy %0d of %0d",
                 n_full, n_empty, peak_count, DEPTH);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("%0t: timeout, %0d requests pending, %0d responses awaited",
                 $time, pending_reqs.size(), awaited_rsps.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
